FILE: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg : shared types and constants
// Widths, defaults and the control bundle handed to every cell of the chain.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int CH_W        = 8;
    localparam int COUNT_W     = 20;
    localparam int M_DATA_W    = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [CH_W-1:0] ch_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } tag_t;

endpackage

FILE: src/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell : one length cell of the chain
// Holds one history byte, its occupancy flag and the palindrome-end bit for
// one length.
// ----------------------------------------------------------------------------
module psc_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  psc_pkg::cell_ctrl_t ctrl,
    input  psc_pkg::ch_t        ch,
    input  psc_pkg::ch_t        prev_hist,
    input  logic                prev_used,
    input  logic                gate,
    output psc_pkg::ch_t        hist,
    output logic                used,
    output logic                ends,
    output logic                hit
);

    psc_pkg::ch_t hist_reg;
    logic         used_reg;
    logic         ends_reg;

    assign hit  = gate && (prev_hist == ch);
    assign hist = hist_reg;
    assign used = used_reg;
    assign ends = ends_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            hist_reg <= prev_hist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            ends_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            used_reg <= 1'b0;
            ends_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            used_reg <= prev_used;
            ends_reg <= hit;
        end
    end

endmodule

FILE: src/psc_sum_tree.sv
// ----------------------------------------------------------------------------
// psc_sum_tree : registered population-count tree
// Binary adder tree over the hit bits, one register level per tree level.
// ----------------------------------------------------------------------------
module psc_sum_tree
#(
    parameter int N  = psc_pkg::MAX_LEN_DEF,
    parameter int CW = $clog2(N + 1)
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [N-1:0]  leaves,
    output logic [CW-1:0] sum
);

    localparam int D  = $clog2(N);
    localparam int NP = 1 << D;

    logic [CW-1:0] leaf_w [NP];
    logic [CW-1:0] node_reg [1:NP-1];

    genvar j;
    generate
        for (j = 0; j < NP; j++)
        begin : g_leaf
            if (j < N)
            begin : g_real
                assign leaf_w[j] = CW'(leaves[j]);
            end
            else
            begin : g_pad
                assign leaf_w[j] = '0;
            end
        end

        for (j = 1; j < NP; j++)
        begin : g_node
            if (2 * j >= NP)
            begin : g_low
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node_reg[j] <= leaf_w[2*j-NP] + leaf_w[2*j+1-NP];
                    end
                end
            end
            else
            begin : g_up
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node_reg[j] <= node_reg[2*j] + node_reg[2*j+1];
                    end
                end
            end
        end
    endgenerate

    assign sum = node_reg[1];

endmodule

FILE: src/palindrome_substring_counter_unit.sv
// ----------------------------------------------------------------------------
// palindrome_substring_counter_unit : palindromic substring counter
// Result: m_tvalid is registered behind the last level of the count tree.
// Throughput: one byte per cycle; the length cells update in parallel and the
// count tree is pipelined. Input stalls only when a second result reaches the
// output register while the first is still waiting.
// Reset: asynchronous, active low; clears cell bits, length, total and flags.
// ----------------------------------------------------------------------------
module palindrome_substring_counter_unit
#(
    parameter int MAX_LEN = psc_pkg::MAX_LEN_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psc_pkg::CH_W-1:0]      s_tdata,   // [7:0] ch
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psc_pkg::M_DATA_W-1:0]  m_tdata,   // [19:0] count, rest zero
    output logic [0:0]                    m_tuser    // [0] overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int D  = $clog2(MAX_LEN);

    logic                         en;
    logic                         acc;
    logic                         room;
    logic                         ovf_now;
    psc_pkg::cell_ctrl_t          ctrl;
    psc_pkg::ch_t                 hist_w [MAX_LEN];
    logic [MAX_LEN-1:0]           used_w;
    logic [MAX_LEN-1:0]           ends_w;
    logic [MAX_LEN-1:0]           hit_w;
    logic [MAX_LEN-1:0]           leaves;
    logic [CW-1:0]                tree_sum;

    logic [LW-1:0]                len_reg;
    logic                         ovf_reg;
    psc_pkg::tag_t                tag_reg [D];
    logic [psc_pkg::COUNT_W-1:0]  total_reg;
    logic [psc_pkg::COUNT_W-1:0]  total_next;
    logic [psc_pkg::COUNT_W:0]    total_sum;
    logic                         out_valid_reg;
    logic [psc_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         out_ovf_reg;
    psc_pkg::tag_t                tag_end;

    assign tag_end    = tag_reg[D-1];
    assign en         = !(out_valid_reg && !m_tready && tag_end.valid && tag_end.last);
    assign s_tready   = en;
    assign acc        = s_tvalid && en;
    assign room       = (len_reg != LW'(MAX_LEN));
    assign ovf_now    = ovf_reg || (acc && !room);
    assign ctrl.shift = acc && room;
    assign ctrl.clr   = acc && s_tlast;
    assign leaves     = ctrl.shift ? hit_w : '0;

    genvar k;
    generate
        for (k = 0; k < MAX_LEN; k++)
        begin : g_cell
            psc_pkg::ch_t prev_hist;
            logic         prev_used;
            logic         gate;

            if (k == 0)
            begin : g_first
                assign prev_hist = s_tdata;
                assign prev_used = 1'b1;
                assign gate      = 1'b1;
            end
            else if (k == 1)
            begin : g_second
                assign prev_hist = hist_w[0];
                assign prev_used = used_w[0];
                assign gate      = (len_reg != '0);
            end
            else
            begin : g_rest
                assign prev_hist = hist_w[k-1];
                assign prev_used = used_w[k-1];
                // the compared byte must lie within the current string
                assign gate      = ends_w[k-2] && used_w[k-1];
            end

            psc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .ch        (s_tdata),
                .prev_hist (prev_hist),
                .prev_used (prev_used),
                .gate      (gate),
                .hist      (hist_w[k]),
                .used      (used_w[k]),
                .ends      (ends_w[k]),
                .hit       (hit_w[k])
            );
        end
    endgenerate

    psc_sum_tree
    #(
        .N  (MAX_LEN),
        .CW (CW)
    )
    u_tree
    (
        .clk    (clk),
        .en     (en),
        .leaves (leaves),
        .sum    (tree_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (acc)
        begin
            if (room)
            begin
                len_reg <= len_reg + LW'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // sideband travels alongside the tree levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= '{valid: acc, last: s_tlast, ovf: ovf_now};
            for (int i = 1; i < D; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_comb
    begin
        total_sum = {1'b0, total_reg} + (psc_pkg::COUNT_W + 1)'(tree_sum);
        if (total_sum > {1'b0, psc_pkg::COUNT_MAX})
        begin
            total_next = psc_pkg::COUNT_MAX;
        end
        else
        begin
            total_next = total_sum[psc_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en && tag_end.valid)
            begin
                total_reg <= tag_end.last ? '0 : total_next;
            end
            if (en && tag_end.valid && tag_end.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tag_end.valid && tag_end.last)
        begin
            out_count_reg <= total_next;
            out_ovf_reg   <= tag_end.ovf;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = psc_pkg::M_DATA_W'(out_count_reg);
    assign m_tuser[0] = out_ovf_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN))
        else $error("length count beyond MAX_LEN");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clr |=> (len_reg == '0) && !ovf_reg && (ends_w == '0))
        else $error("state not cleared after last beat");

    a_len_one_set: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift && !ctrl.clr |=> ends_w[0])
        else $error("single-byte palindrome bit missing");

endmodule

FILE: bench/palindrome_substring_counter_unit_tb.sv
// ----------------------------------------------------------------------------
// palindrome_substring_counter_unit_tb : self-checking bench for the counter
// Streams byte strings into the unit and checks every per-string total and
// overflow flag against a cycle-free model kept in step with accepted beats.
// Covers byte extremes, odd and even palindromes, a string past the length
// cap, a long output hold-off and random strings with random idling.
// ----------------------------------------------------------------------------
module palindrome_substring_counter_unit_tb;

    import psc_pkg::*;

    localparam int LEN_CAP     = MAX_LEN_DEF;
    localparam int DRAIN_WAIT  = $clog2(LEN_CAP) + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 720;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } string_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [CH_W-1:0]     s_tdata;     // [7:0] ch
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;     // [19:0] count, rest zero
    logic [0:0]          m_tuser;     // [0] overflow

    // model state
    ch_t         seen_chars[LEN_CAP];
    bit          pal_end[LEN_CAP];
    int unsigned chars_taken;
    int unsigned pal_tally;
    bit          cut_short;

    string_result_t owed_results[$];
    int unsigned    faults;
    int unsigned    cycles;
    int unsigned    random_sent;
    bit             steady;
    bit             hold_pending;

    palindrome_substring_counter_unit #(.MAX_LEN(LEN_CAP)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_tally();
        foreach (seen_chars[i])
        begin
            seen_chars[i] = '0;
            pal_end[i]    = 1'b0;
        end
        chars_taken = 0;
        pal_tally   = 0;
        cut_short   = 1'b0;
    endtask

    task automatic absorb_char(input ch_t c, input bit fin);
        int unsigned    n;
        int unsigned    added;
        int unsigned    span;
        int unsigned    ceiling;
        bit             hit;
        string_result_t res;
        ceiling = COUNT_MAX;
        if (chars_taken < LEN_CAP)
        begin
            n     = chars_taken;
            added = 1;
            // walk downward so each length still sees the old L-2 bit
            for (span = n + 1; span >= 3; span--)
            begin
                hit = pal_end[span-3] && (seen_chars[n-span+1] == c);
                pal_end[span-1] = hit;
                added += hit;
            end
            if (n >= 1)
            begin
                hit = (seen_chars[n-1] == c);
                pal_end[1] = hit;
                added += hit;
            end
            pal_end[0]    = 1'b1;
            seen_chars[n] = c;
            chars_taken   = n + 1;
            pal_tally     = (added > ceiling - pal_tally) ? ceiling : pal_tally + added;
        end
        else
        begin
            cut_short = 1'b1;
        end
        if (fin)
        begin
            res.count    = pal_tally[COUNT_W-1:0];
            res.overflow = cut_short;
            owed_results.push_back(res);
            clear_tally();
        end
    endtask

    task automatic note_fault(input string what, input string_result_t want,
                              input string_result_t got);
        faults++;
        if (faults <= 10)
            $display("%s: expected count %0d ovf %0b, got count %0d ovf %0b",
                     what, want.count, want.overflow, got.count, got.overflow);
    endtask

    task automatic send_char(input ch_t c, input bit fin);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_char(c, fin);
    endtask

    task automatic send_string(input ch_t text[$]);
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic test_byte_extremes();
        send_string('{8'h00});
        send_string('{8'hFF});
        send_string('{8'h00, 8'h00});
        send_string('{8'hFF, 8'hFF});
        send_string('{8'h00, 8'hFF});
        send_string('{8'hA5, 8'h5A, 8'hA5});
    endtask

    task automatic test_odd_even();
        send_string('{"a", "b", "c", "b", "a"});
        send_string('{"a", "b", "b", "a"});
        send_string('{"x", "x", "x", "x", "x", "x"});
    endtask

    // fills the history, then two dropped bytes, last flag on a dropped one
    task automatic test_length_overflow();
        ch_t text[$];
        repeat (LEN_CAP + 2)
            text.push_back(8'h61);
        steady = 1'b1;
        send_string(text);
        steady = 1'b0;
    endtask

    task automatic test_output_hold();
        ch_t text[$];
        hold_pending = 1'b1;
        repeat (40)
        begin
            text.delete();
            repeat ($urandom_range(1, 3))
                text.push_back(ch_t'($urandom_range(0, 255)));
            send_string(text);
        end
    endtask

    task automatic test_random_strings();
        ch_t   text[$];
        ch_t   pick_a;
        ch_t   pick_b;
        int    len;
        int    kind;
        random_sent = 0;
        while (random_sent < RANDOM_BEATS)
        begin
            steady = (random_sent >= RANDOM_BEATS / 3 && random_sent < RANDOM_BEATS / 2);
            text.delete();
            kind   = $urandom_range(0, 3);
            pick_a = ch_t'($urandom);
            pick_b = ch_t'($urandom);
            case (kind)
                0:
                begin
                    len = $urandom_range(1, 12);
                    repeat (len)
                        text.push_back(ch_t'($urandom));
                end
                1:
                begin
                    len = $urandom_range(1, 40);
                    repeat (len)
                        text.push_back($urandom_range(0, 1) ? pick_a : pick_b);
                end
                2:
                begin
                    len = $urandom_range(1, 15);
                    repeat (len)
                        text.push_back(ch_t'($urandom_range(0, 3)) ^ pick_a);
                    for (int i = len - 1 - $urandom_range(0, 1); i >= 0; i--)
                        text.push_back(text[i]);
                end
                default:
                begin
                    len = $urandom_range(1, 20);
                    repeat (len)
                        text.push_back(pick_a);
                end
            endcase
            send_string(text);
            random_sent += text.size();
        end
        steady = 1'b0;
    endtask

    // result checker
    initial
    begin
        string_result_t want;
        string_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.count    = m_tdata[COUNT_W-1:0];
                got.overflow = m_tuser[0];
                if (owed_results.size() == 0)
                begin
                    want = '0;
                    note_fault("unexpected beat", want, got);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got !== want)
                        note_fault("mismatch", want, got);
                end
            end
        end
    end

    // receiver: random idling plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        string_result_t nothing;
        nothing      = '0;
        faults       = 0;
        steady       = 1'b0;
        hold_pending = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        clear_tally();
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_byte_extremes();
        test_odd_even();
        test_length_overflow();
        test_output_hold();
        test_random_strings();

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        while (owed_results.size() != 0)
            note_fault("missing beat", owed_results.pop_front(), nothing);

        if (faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
